[rtl/qapm_pkg.sv]
// Shared widths, reset values, register indexes and the action bundle of the
// quadcopter attitude controller. No dependencies.
`default_nettype none

package qapm_pkg;

  // Field widths of the command and motor transactions.
  localparam int PULSE_W    = 12;
  localparam int CMD_W      = 10;
  localparam int HRATE_W    = 14;
  localparam int RATE_W     = 16;
  localparam int TILT_W     = 13;
  localparam int YAW_W      = 14;

  // Configuration port and register widths.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int GAIN_W     = 16;
  localparam int LIM_W      = 10;

  // Width of one clamped axis action in whole microseconds.
  localparam int ACT_W      = 11;

  localparam logic [PULSE_W-1:0] ARM_LEVEL  = 12'd1500;
  localparam logic [PULSE_W-1:0] IDLE_PULSE = 12'd1000;

  // Register values after reset.
  localparam logic [GAIN_W-1:0]  KP_RATE_RST      = 16'd256;
  localparam logic [GAIN_W-1:0]  KP_YAW_RST       = 16'd512;
  localparam logic [GAIN_W-1:0]  KI_ANGLE_RST     = 16'd435;
  localparam logic [GAIN_W-1:0]  KD_RATE_RST      = 16'd0;
  localparam logic [GAIN_W-1:0]  KD_YAW_RST       = 16'd1536;
  localparam logic [LIM_W-1:0]   ACTION_LIMIT_RST = 10'd300;
  localparam logic [PULSE_W-1:0] MIN_PULSE_RST    = 12'd1100;
  localparam logic [PULSE_W-1:0] MAX_PULSE_RST    = 12'd2000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KP_RATE      = 3'd0,
    REG_KP_YAW       = 3'd1,
    REG_KI_ANGLE     = 3'd2,
    REG_KD_RATE      = 3'd3,
    REG_KD_YAW       = 3'd4,
    REG_ACTION_LIMIT = 3'd5,
    REG_MIN_PULSE    = 3'd6,
    REG_MAX_PULSE    = 3'd7
  } qapm_reg_t;

  // Clamped axis actions and throttle handed to the motor mixer.
  typedef struct packed {
    logic                    armed;
    logic [PULSE_W-1:0]      thr;
    logic signed [ACT_W-1:0] pitch;
    logic signed [ACT_W-1:0] roll;
    logic signed [ACT_W-1:0] yaw;
  } qapm_act_t;

endpackage

`default_nettype wire

[rtl/qapm_if.sv]
// Valid/ready channel interfaces for the command input and the motor output
// of the attitude controller. Depends on qapm_pkg for the field widths.
`default_nettype none

interface qapm_in_if;
  logic                                   valid;
  logic                                   ready;
  logic [qapm_pkg::PULSE_W-1:0]           throttle_pulse;
  logic [qapm_pkg::PULSE_W-1:0]           arm_pulse;
  logic signed [qapm_pkg::CMD_W-1:0]      cmd_pitch_rate;
  logic signed [qapm_pkg::CMD_W-1:0]      cmd_roll_rate;
  logic signed [qapm_pkg::CMD_W-1:0]      cmd_yaw_rate;
  logic signed [qapm_pkg::HRATE_W-1:0]    heading_rate;
  logic signed [qapm_pkg::RATE_W-1:0]     meas_pitch_rate;
  logic signed [qapm_pkg::RATE_W-1:0]     meas_roll_rate;
  logic signed [qapm_pkg::RATE_W-1:0]     meas_yaw_rate;
  logic signed [qapm_pkg::TILT_W-1:0]     meas_pitch;
  logic signed [qapm_pkg::TILT_W-1:0]     meas_roll;
  logic signed [qapm_pkg::YAW_W-1:0]      meas_yaw;

  modport source (
    output valid, throttle_pulse, arm_pulse, cmd_pitch_rate, cmd_roll_rate,
           cmd_yaw_rate, heading_rate, meas_pitch_rate, meas_roll_rate,
           meas_yaw_rate, meas_pitch, meas_roll, meas_yaw,
    input  ready
  );

  modport sink (
    input  valid, throttle_pulse, arm_pulse, cmd_pitch_rate, cmd_roll_rate,
           cmd_yaw_rate, heading_rate, meas_pitch_rate, meas_roll_rate,
           meas_yaw_rate, meas_pitch, meas_roll, meas_yaw,
    output ready
  );
endinterface

interface qapm_out_if;
  logic                         valid;
  logic                         ready;
  logic [qapm_pkg::PULSE_W-1:0] motor_one;
  logic [qapm_pkg::PULSE_W-1:0] motor_two;
  logic [qapm_pkg::PULSE_W-1:0] motor_three;
  logic [qapm_pkg::PULSE_W-1:0] motor_four;

  modport source (
    output valid, motor_one, motor_two, motor_three, motor_four,
    input  ready
  );

  modport sink (
    input  valid, motor_one, motor_two, motor_three, motor_four,
    output ready
  );
endinterface

`default_nettype wire

[rtl/qapm_mixer.sv]
// X-configuration motor mixer with pulse clamping and the output register.
// Depends on qapm_pkg for the action bundle and the idle pulse.
`default_nettype none

module qapm_mixer (
  input  logic                         clk,
  input  logic                         en,
  input  qapm_pkg::qapm_act_t          act,
  input  logic [qapm_pkg::PULSE_W-1:0] min_pulse,
  input  logic [qapm_pkg::PULSE_W-1:0] max_pulse,
  output logic [qapm_pkg::PULSE_W-1:0] motor_one,
  output logic [qapm_pkg::PULSE_W-1:0] motor_two,
  output logic [qapm_pkg::PULSE_W-1:0] motor_three,
  output logic [qapm_pkg::PULSE_W-1:0] motor_four
);

  localparam int SUM_W = qapm_pkg::PULSE_W + 2;

  // The upper bound is applied first, so a minimum above the maximum wins.
  function automatic logic [qapm_pkg::PULSE_W-1:0] clamp_pulse(
    input logic signed [SUM_W-1:0]        s,
    input logic [qapm_pkg::PULSE_W-1:0]   lo,
    input logic [qapm_pkg::PULSE_W-1:0]   hi
  );
    logic signed [SUM_W-1:0] v;
    v = s;
    if (v > $signed({2'b00, hi})) v = $signed({2'b00, hi});
    if (v < $signed({2'b00, lo})) v = $signed({2'b00, lo});
    return v[qapm_pkg::PULSE_W-1:0];
  endfunction

  logic signed [SUM_W-1:0] thr_s;
  logic signed [SUM_W-1:0] pitch_s;
  logic signed [SUM_W-1:0] roll_s;
  logic signed [SUM_W-1:0] yaw_s;
  logic signed [SUM_W-1:0] sum_one;
  logic signed [SUM_W-1:0] sum_two;
  logic signed [SUM_W-1:0] sum_three;
  logic signed [SUM_W-1:0] sum_four;

  assign thr_s   = $signed({2'b00, act.thr});
  assign pitch_s = SUM_W'(act.pitch);
  assign roll_s  = SUM_W'(act.roll);
  assign yaw_s   = SUM_W'(act.yaw);

  assign sum_one   = thr_s - roll_s + pitch_s + yaw_s;
  assign sum_two   = thr_s - roll_s - pitch_s - yaw_s;
  assign sum_three = thr_s + roll_s - pitch_s + yaw_s;
  assign sum_four  = thr_s + roll_s + pitch_s - yaw_s;

  always_ff @(posedge clk) begin
    if (en) begin
      if (act.armed) begin
        motor_one   <= clamp_pulse(sum_one, min_pulse, max_pulse);
        motor_two   <= clamp_pulse(sum_two, min_pulse, max_pulse);
        motor_three <= clamp_pulse(sum_three, min_pulse, max_pulse);
        motor_four  <= clamp_pulse(sum_four, min_pulse, max_pulse);
      end else begin
        motor_one   <= qapm_pkg::IDLE_PULSE;
        motor_two   <= qapm_pkg::IDLE_PULSE;
        motor_three <= qapm_pkg::IDLE_PULSE;
        motor_four  <= qapm_pkg::IDLE_PULSE;
      end
    end
  end

endmodule

`default_nettype wire

[rtl/quad_attitude_pid_mixer.sv]
// Top level of the quadcopter attitude controller: pipeline, heading and rate
// error state, configuration registers. Depends on qapm_pkg, qapm_if, qapm_mixer.
`default_nettype none

// One command transaction per control tick goes in on cmd_in and one motor
// transaction with four pulse widths comes out on motor_out. The block takes a
// new transaction in every cycle unless the output side stalls. The pipeline has
// seven register stages: the input register, the heading increment (a multiply
// by the reciprocal of the tick rate), the heading setpoint and rate error
// difference update, the heading error wrap, the gain products, the clamped
// axis actions, and the motor mixer's output register. The state that carries
// from one tick to the next (heading setpoint and previous pitch and roll rate
// errors) closes within the second stage, which is what lets one transaction
// follow the next without a gap. When the output transaction is held because
// ready is low, the whole pipeline holds and cmd_in.ready drops in the same
// cycle. Gains are unsigned Q8.8; angles and rates are in 1/16 degree units,
// the heading setpoint carries 8 more fraction bits. While the arm pulse is
// below 1500 us all motors read 1000 us and the setpoint follows measured yaw.
// Registers are written through cfg_we, cfg_index and cfg_data, and should
// only be changed while no transaction is in flight.
module quad_attitude_pid_mixer (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [qapm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [qapm_pkg::CFG_DATA_W-1:0] cfg_data,
  qapm_in_if.sink                         cmd_in,
  qapm_out_if.source                      motor_out
);

  // Internal widths of the error and product terms.
  localparam int ERR_W   = 17;   // rate error, cmd*16 - measured
  localparam int DERR_W  = 18;   // change of the rate error
  localparam int HDG_W   = 22;   // heading setpoint and scaled yaw
  localparam int HERR_W  = 23;   // wrapped heading error
  localparam int WIDE_W  = 24;   // headroom for setpoint arithmetic
  localparam int HQ_W    = 14;   // magnitude of the heading increment
  localparam int HNUM_W  = 22;
  localparam int RCP_W   = 23;
  localparam int HPROD_W = HNUM_W + RCP_W;
  localparam int SGAIN_W = qapm_pkg::GAIN_W + 1;
  localparam int KPP_W   = SGAIN_W + ERR_W;
  localparam int KDP_W   = SGAIN_W + DERR_W;
  localparam int KIP_W   = SGAIN_W + qapm_pkg::TILT_W;
  localparam int YP_W    = SGAIN_W + HERR_W;
  localparam int YD_W    = SGAIN_W + ERR_W;
  localparam int PR_SUM_W  = 36;
  localparam int YAW_SUM_W = 43;
  localparam int PR_SHIFT  = 12;  // Q8.8 gain times 1/16 units
  localparam int YAW_SHIFT = 20;  // Q8.8 gain times 1/4096 units

  // Heading increment: round(hr*256/250) computed as floor(n/250) with
  // n = |hr|*256 + 125, using an exact reciprocal for n below 2^22.
  localparam logic [HNUM_W-1:0] HALF_TICK  = 22'd125;
  localparam logic [RCP_W-1:0]  RECIP_250  = 23'd4294968;
  localparam int                RECIP_SHIFT = 30;

  localparam logic signed [WIDE_W-1:0] FULL_TURN = 24'sd1474560;
  localparam logic signed [WIDE_W-1:0] HALF_TURN = 24'sd737280;

  typedef struct packed {
    logic [qapm_pkg::PULSE_W-1:0]        thr;
    logic [qapm_pkg::PULSE_W-1:0]        arm;
    logic signed [qapm_pkg::CMD_W-1:0]   cp;
    logic signed [qapm_pkg::CMD_W-1:0]   cr;
    logic signed [qapm_pkg::CMD_W-1:0]   cy;
    logic signed [qapm_pkg::HRATE_W-1:0] hr;
    logic signed [qapm_pkg::RATE_W-1:0]  mpr;
    logic signed [qapm_pkg::RATE_W-1:0]  mrr;
    logic signed [qapm_pkg::RATE_W-1:0]  myr;
    logic signed [qapm_pkg::TILT_W-1:0]  mp;
    logic signed [qapm_pkg::TILT_W-1:0]  mr;
    logic signed [qapm_pkg::YAW_W-1:0]   my;
  } s0_t;

  typedef struct packed {
    logic                               armed;
    logic [qapm_pkg::PULSE_W-1:0]       thr;
    logic signed [ERR_W-1:0]            ep;
    logic signed [ERR_W-1:0]            er;
    logic signed [ERR_W-1:0]            eyr;
    logic [HQ_W-1:0]                    hq;
    logic                               hneg;
    logic signed [HDG_W-1:0]            myq;
    logic signed [qapm_pkg::TILT_W-1:0] mp;
    logic signed [qapm_pkg::TILT_W-1:0] mr;
  } s1_t;

  typedef struct packed {
    logic                               armed;
    logic [qapm_pkg::PULSE_W-1:0]       thr;
    logic signed [HDG_W-1:0]            sp;
    logic signed [HDG_W-1:0]            myq;
    logic signed [ERR_W-1:0]            ep;
    logic signed [ERR_W-1:0]            er;
    logic signed [ERR_W-1:0]            eyr;
    logic signed [DERR_W-1:0]           dp;
    logic signed [DERR_W-1:0]           dr;
    logic signed [qapm_pkg::TILT_W-1:0] mp;
    logic signed [qapm_pkg::TILT_W-1:0] mr;
  } s2_t;

  typedef struct packed {
    logic                               armed;
    logic [qapm_pkg::PULSE_W-1:0]       thr;
    logic signed [HERR_W-1:0]           eh;
    logic signed [ERR_W-1:0]            ep;
    logic signed [ERR_W-1:0]            er;
    logic signed [ERR_W-1:0]            eyr;
    logic signed [DERR_W-1:0]           dp;
    logic signed [DERR_W-1:0]           dr;
    logic signed [qapm_pkg::TILT_W-1:0] mp;
    logic signed [qapm_pkg::TILT_W-1:0] mr;
  } s3_t;

  typedef struct packed {
    logic                         armed;
    logic [qapm_pkg::PULSE_W-1:0] thr;
    logic signed [KPP_W-1:0]      kpp_p;
    logic signed [KDP_W-1:0]      kdp_p;
    logic signed [KIP_W-1:0]      kip_p;
    logic signed [KPP_W-1:0]      kpp_r;
    logic signed [KDP_W-1:0]      kdp_r;
    logic signed [KIP_W-1:0]      kip_r;
    logic signed [YP_W-1:0]       yp;
    logic signed [YD_W-1:0]       yd;
  } s4_t;

  // Clamp to +-limit (limit in microseconds scaled by the fraction bits),
  // then truncate toward zero to whole microseconds.
  function automatic logic signed [qapm_pkg::ACT_W-1:0] clamp_pr(
    input logic signed [PR_SUM_W-1:0]   v,
    input logic [qapm_pkg::LIM_W-1:0]   lim
  );
    logic signed [PR_SUM_W-1:0] hi;
    logic signed [PR_SUM_W-1:0] c;
    logic signed [PR_SUM_W-1:0] r;
    hi = $signed({{(PR_SUM_W - qapm_pkg::LIM_W - PR_SHIFT){1'b0}}, lim,
                  {PR_SHIFT{1'b0}}});
    if (v > hi) c = hi;
    else if (v < -hi) c = -hi;
    else c = v;
    r = c[PR_SUM_W-1] ? c + $signed({{(PR_SUM_W - PR_SHIFT){1'b0}}, {PR_SHIFT{1'b1}}})
                      : c;
    return r[PR_SHIFT +: qapm_pkg::ACT_W];
  endfunction

  function automatic logic signed [qapm_pkg::ACT_W-1:0] clamp_yaw(
    input logic signed [YAW_SUM_W-1:0]  v,
    input logic [qapm_pkg::LIM_W-1:0]   lim
  );
    logic signed [YAW_SUM_W-1:0] hi;
    logic signed [YAW_SUM_W-1:0] c;
    logic signed [YAW_SUM_W-1:0] r;
    hi = $signed({{(YAW_SUM_W - qapm_pkg::LIM_W - YAW_SHIFT){1'b0}}, lim,
                  {YAW_SHIFT{1'b0}}});
    if (v > hi) c = hi;
    else if (v < -hi) c = -hi;
    else c = v;
    r = c[YAW_SUM_W-1] ? c + $signed({{(YAW_SUM_W - YAW_SHIFT){1'b0}}, {YAW_SHIFT{1'b1}}})
                       : c;
    return r[YAW_SHIFT +: qapm_pkg::ACT_W];
  endfunction

  // Configuration registers.
  logic [qapm_pkg::GAIN_W-1:0]  kp_rate;
  logic [qapm_pkg::GAIN_W-1:0]  kp_yaw;
  logic [qapm_pkg::GAIN_W-1:0]  ki_angle;
  logic [qapm_pkg::GAIN_W-1:0]  kd_rate;
  logic [qapm_pkg::GAIN_W-1:0]  kd_yaw;
  logic [qapm_pkg::LIM_W-1:0]   action_limit;
  logic [qapm_pkg::PULSE_W-1:0] min_pulse;
  logic [qapm_pkg::PULSE_W-1:0] max_pulse;

  // State carried from tick to tick.
  logic signed [HDG_W-1:0] heading_setpoint;
  logic signed [HDG_W-1:0] heading_setpoint_next;
  logic signed [ERR_W-1:0] prev_pitch_rate_err;
  logic signed [ERR_W-1:0] prev_roll_rate_err;

  // Pipeline registers and their valid bits.
  s0_t s0;
  s1_t s1;
  s1_t s1_next;
  s2_t s2;
  s2_t s2_next;
  s3_t s3;
  s3_t s3_next;
  s4_t s4;
  s4_t s4_next;
  qapm_pkg::qapm_act_t act;
  qapm_pkg::qapm_act_t act_next;
  logic v0, v1, v2, v3, v4, v5;
  logic out_valid;
  logic adv;

  // The whole pipeline moves whenever the output register is free or being
  // emptied in this cycle.
  assign adv = !out_valid || motor_out.ready;
  assign cmd_in.ready = adv;
  assign motor_out.valid = out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      kp_rate      <= qapm_pkg::KP_RATE_RST;
      kp_yaw       <= qapm_pkg::KP_YAW_RST;
      ki_angle     <= qapm_pkg::KI_ANGLE_RST;
      kd_rate      <= qapm_pkg::KD_RATE_RST;
      kd_yaw       <= qapm_pkg::KD_YAW_RST;
      action_limit <= qapm_pkg::ACTION_LIMIT_RST;
      min_pulse    <= qapm_pkg::MIN_PULSE_RST;
      max_pulse    <= qapm_pkg::MAX_PULSE_RST;
    end else if (cfg_we) begin
      unique case (qapm_pkg::qapm_reg_t'(cfg_index))
        qapm_pkg::REG_KP_RATE:      kp_rate      <= cfg_data;
        qapm_pkg::REG_KP_YAW:       kp_yaw       <= cfg_data;
        qapm_pkg::REG_KI_ANGLE:     ki_angle     <= cfg_data;
        qapm_pkg::REG_KD_RATE:      kd_rate      <= cfg_data;
        qapm_pkg::REG_KD_YAW:       kd_yaw       <= cfg_data;
        qapm_pkg::REG_ACTION_LIMIT: action_limit <= cfg_data[qapm_pkg::LIM_W-1:0];
        qapm_pkg::REG_MIN_PULSE:    min_pulse    <= cfg_data[qapm_pkg::PULSE_W-1:0];
        qapm_pkg::REG_MAX_PULSE:    max_pulse    <= cfg_data[qapm_pkg::PULSE_W-1:0];
      endcase
    end
  end

  // Stage 1: rate errors, armed decision and the heading increment magnitude.
  logic [HQ_W-1:0]    hmag;
  logic [HNUM_W-1:0]  hnum;
  logic [HPROD_W-1:0] hprod;

  assign hmag  = s0.hr[qapm_pkg::HRATE_W-1] ? HQ_W'(-s0.hr) : HQ_W'(s0.hr);
  assign hnum  = {hmag, 8'b0} + HALF_TICK;
  assign hprod = hnum * RECIP_250;

  always_comb begin
    s1_next.armed = s0.arm >= qapm_pkg::ARM_LEVEL;
    s1_next.thr   = s0.thr;
    s1_next.ep    = (ERR_W'(s0.cp) <<< 4) - ERR_W'(s0.mpr);
    s1_next.er    = (ERR_W'(s0.cr) <<< 4) - ERR_W'(s0.mrr);
    s1_next.eyr   = (ERR_W'(s0.cy) <<< 4) - ERR_W'(s0.myr);
    s1_next.hq    = hprod[RECIP_SHIFT +: HQ_W];
    s1_next.hneg  = s0.hr[qapm_pkg::HRATE_W-1];
    s1_next.myq   = $signed({s0.my, 8'b0});
    s1_next.mp    = s0.mp;
    s1_next.mr    = s0.mr;
  end

  // Stage 2: heading setpoint advance with one wrap into 0..360 degrees (or the
  // measured yaw while disarmed), and the change of the rate errors since the previous tick.
  logic signed [WIDE_W-1:0] hinc;
  logic signed [WIDE_W-1:0] sp_sum;
  logic signed [WIDE_W-1:0] sp_wrap;

  always_comb begin
    hinc   = $signed({{(WIDE_W - HQ_W){1'b0}}, s1.hq});
    if (s1.hneg) hinc = -hinc;
    sp_sum = WIDE_W'(heading_setpoint) + hinc;
    priority if (!s1.armed) sp_wrap = WIDE_W'(s1.myq);
    else if (sp_sum < 0) sp_wrap = sp_sum + FULL_TURN;
    else if (sp_sum > FULL_TURN) sp_wrap = sp_sum - FULL_TURN;
    else sp_wrap = sp_sum;
    heading_setpoint_next = sp_wrap[HDG_W-1:0];

    s2_next.armed = s1.armed;
    s2_next.thr   = s1.thr;
    s2_next.sp    = heading_setpoint_next;
    s2_next.myq   = s1.myq;
    s2_next.ep    = s1.ep;
    s2_next.er    = s1.er;
    s2_next.eyr   = s1.eyr;
    s2_next.dp    = DERR_W'(s1.ep) - DERR_W'(prev_pitch_rate_err);
    s2_next.dr    = DERR_W'(s1.er) - DERR_W'(prev_roll_rate_err);
    s2_next.mp    = s1.mp;
    s2_next.mr    = s1.mr;
  end

  // Stage 3: heading error wrapped toward +-180 degrees, one correction each.
  logic signed [WIDE_W-1:0] hdiff;
  logic signed [WIDE_W-1:0] hwrap;

  always_comb begin
    hdiff = WIDE_W'(s2.sp) - WIDE_W'(s2.myq);
    priority if (hdiff > HALF_TURN) hwrap = hdiff - FULL_TURN;
    else if (hdiff < -HALF_TURN) hwrap = hdiff + FULL_TURN;
    else hwrap = hdiff;

    s3_next.armed = s2.armed;
    s3_next.thr   = s2.thr;
    s3_next.eh    = hwrap[HERR_W-1:0];
    s3_next.ep    = s2.ep;
    s3_next.er    = s2.er;
    s3_next.eyr   = s2.eyr;
    s3_next.dp    = s2.dp;
    s3_next.dr    = s2.dr;
    s3_next.mp    = s2.mp;
    s3_next.mr    = s2.mr;
  end

  // Stage 4: one multiplier per gain term.
  logic signed [SGAIN_W-1:0] kp_rate_s;
  logic signed [SGAIN_W-1:0] kd_rate_s;
  logic signed [SGAIN_W-1:0] ki_angle_s;
  logic signed [SGAIN_W-1:0] kp_yaw_s;
  logic signed [SGAIN_W-1:0] kd_yaw_s;

  assign kp_rate_s  = $signed({1'b0, kp_rate});
  assign kd_rate_s  = $signed({1'b0, kd_rate});
  assign ki_angle_s = $signed({1'b0, ki_angle});
  assign kp_yaw_s   = $signed({1'b0, kp_yaw});
  assign kd_yaw_s   = $signed({1'b0, kd_yaw});

  always_comb begin
    s4_next.armed = s3.armed;
    s4_next.thr   = s3.thr;
    s4_next.kpp_p = kp_rate_s * s3.ep;
    s4_next.kdp_p = kd_rate_s * s3.dp;
    s4_next.kip_p = ki_angle_s * s3.mp;
    s4_next.kpp_r = kp_rate_s * s3.er;
    s4_next.kdp_r = kd_rate_s * s3.dr;
    s4_next.kip_r = ki_angle_s * s3.mr;
    s4_next.yp    = kp_yaw_s * s3.eh;
    s4_next.yd    = kd_yaw_s * s3.eyr;
  end

  // Stage 5: sum the terms of each axis, clamp and truncate. The angle term
  // enters with a minus sign since the level target is zero.
  logic signed [PR_SUM_W-1:0]  sum_pitch;
  logic signed [PR_SUM_W-1:0]  sum_roll;
  logic signed [YAW_SUM_W-1:0] sum_yaw;

  assign sum_pitch = PR_SUM_W'(s4.kpp_p) + PR_SUM_W'(s4.kdp_p) - PR_SUM_W'(s4.kip_p);
  assign sum_roll  = PR_SUM_W'(s4.kpp_r) + PR_SUM_W'(s4.kdp_r) - PR_SUM_W'(s4.kip_r);
  assign sum_yaw   = YAW_SUM_W'(s4.yp) + (YAW_SUM_W'(s4.yd) <<< 8);

  always_comb begin
    act_next.armed = s4.armed;
    act_next.thr   = s4.thr;
    act_next.pitch = clamp_pr(sum_pitch, action_limit);
    act_next.roll  = clamp_pr(sum_roll, action_limit);
    act_next.yaw   = clamp_yaw(sum_yaw, action_limit);
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (adv) begin
      s0.thr <= cmd_in.throttle_pulse;
      s0.arm <= cmd_in.arm_pulse;
      s0.cp  <= cmd_in.cmd_pitch_rate;
      s0.cr  <= cmd_in.cmd_roll_rate;
      s0.cy  <= cmd_in.cmd_yaw_rate;
      s0.hr  <= cmd_in.heading_rate;
      s0.mpr <= cmd_in.meas_pitch_rate;
      s0.mrr <= cmd_in.meas_roll_rate;
      s0.myr <= cmd_in.meas_yaw_rate;
      s0.mp  <= cmd_in.meas_pitch;
      s0.mr  <= cmd_in.meas_roll;
      s0.my  <= cmd_in.meas_yaw;
      s1     <= s1_next;
      s2     <= s2_next;
      s3     <= s3_next;
      s4     <= s4_next;
      act    <= act_next;
    end
  end

  // Valid bits, output valid and the tick-to-tick state.
  always_ff @(posedge clk) begin
    if (rst) begin
      v0                  <= 1'b0;
      v1                  <= 1'b0;
      v2                  <= 1'b0;
      v3                  <= 1'b0;
      v4                  <= 1'b0;
      v5                  <= 1'b0;
      out_valid           <= 1'b0;
      heading_setpoint    <= '0;
      prev_pitch_rate_err <= '0;
      prev_roll_rate_err  <= '0;
    end else if (adv) begin
      v0        <= cmd_in.valid;
      v1        <= v0;
      v2        <= v1;
      v3        <= v2;
      v4        <= v3;
      v5        <= v4;
      out_valid <= v5;
      if (v1) begin
        heading_setpoint    <= heading_setpoint_next;
        prev_pitch_rate_err <= s1.ep;
        prev_roll_rate_err  <= s1.er;
      end
    end
  end

  qapm_mixer u_mixer (
    .clk         (clk),
    .en          (adv),
    .act         (act),
    .min_pulse   (min_pulse),
    .max_pulse   (max_pulse),
    .motor_one   (motor_out.motor_one),
    .motor_two   (motor_out.motor_two),
    .motor_three (motor_out.motor_three),
    .motor_four  (motor_out.motor_four)
  );

  // An armed tick never leaves the setpoint above one full turn.
  a_setpoint_wrapped: assert property (
    @(posedge clk) disable iff (rst)
    adv && v1 && s1.armed |=> WIDE_W'(heading_setpoint) <= FULL_TURN
  ) else $error("heading setpoint above a full turn after an armed tick");

  // A result only shows up when the action stage held a live transaction.
  a_out_from_pipe: assert property (
    @(posedge clk) disable iff (rst)
    $rose(motor_out.valid) |-> $past(v5)
  ) else $error("motor transaction without a transaction in the action stage");

  // A disarmed tick drives every motor to the idle pulse.
  a_disarmed_idle: assert property (
    @(posedge clk) disable iff (rst)
    adv && v5 && !act.armed |=>
      motor_out.motor_one == qapm_pkg::IDLE_PULSE &&
      motor_out.motor_two == qapm_pkg::IDLE_PULSE &&
      motor_out.motor_three == qapm_pkg::IDLE_PULSE &&
      motor_out.motor_four == qapm_pkg::IDLE_PULSE
  ) else $error("disarmed transaction did not give idle motor pulses");

endmodule

`default_nettype wire
